### src/lrukv_pkg.sv
// lrukv_pkg: shared types and constants of the LRU key-value cache.
// Used by lrukv_ctrl, lrukv_dpath and lru_key_value_cache_unit; no dependencies.
package lrukv_pkg;

  // Field widths
  localparam int KEY_W   = 16;
  localparam int VAL_W   = 32;
  localparam int CAP_W   = 5;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;

  // Capacity register value after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Register index of capacity (byte address bit 2 selects the register)
  localparam logic REG_CAPACITY = 1'b0;

  // Operation codes
  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;   // latch the incoming beat
    logic lookup;   // key compare, slot select, data read
    logic commit;   // apply update and load the result register
  } cmd_t;

endpackage

### src/lrukv_ctrl.sv
// lrukv_ctrl: sequencing of lookup and update for the LRU key-value cache.
// Depends on lrukv_pkg for the state enum and command struct.
module lrukv_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output lrukv_pkg::cmd_t cmd
);

  lrukv_pkg::state_t state_r, state_nxt;
  logic              out_valid_r, out_valid_nxt;

  // State and result-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lrukv_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    cmd       = '0;
    case (state_r)
      lrukv_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = lrukv_pkg::ST_LOOKUP;
        end
      end
      lrukv_pkg::ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_nxt  = lrukv_pkg::ST_UPDATE;
      end
      lrukv_pkg::ST_UPDATE: begin
        // commit only when the result register is free or being drained
        if (!out_valid_r || !out_stall) begin
          cmd.commit = 1'b1;
          in_stall   = 1'b0;
          if (in_valid) begin
            cmd.accept = 1'b1;
            state_nxt  = lrukv_pkg::ST_LOOKUP;
          end else begin
            state_nxt  = lrukv_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = lrukv_pkg::ST_IDLE;
    endcase
  end

  // Result beat stays until taken
  assign out_valid_nxt = cmd.commit | (out_valid_r & out_stall);
  assign out_valid     = out_valid_r;

endmodule

### src/lrukv_dpath.sv
// lrukv_dpath: key CAM, recency ranks, data memory and result register.
// Depends on lrukv_pkg for widths, op codes and the command struct.
module lrukv_dpath #(
  parameter int ENTRIES = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  lrukv_pkg::cmd_t                    cmd,
  input  logic [lrukv_pkg::CAP_W-1:0]        capacity,
  input  logic                               in_op,
  input  logic [lrukv_pkg::KEY_W-1:0]        in_key,
  input  logic signed [lrukv_pkg::VAL_W-1:0] in_value,
  output logic                               out_found,
  output logic signed [lrukv_pkg::VAL_W-1:0] out_read_value
);

  localparam int IW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OW  = $clog2(ENTRIES + 1);
  localparam int CMW = 9;  // holds any capacity and ENTRIES up to 256

  // Request latched on accept
  logic                        op_r;
  logic [lrukv_pkg::KEY_W-1:0] key_q_r;
  logic [lrukv_pkg::VAL_W-1:0] value_r;

  // Entry state
  logic [ENTRIES-1:0]          valid_r;
  logic [lrukv_pkg::KEY_W-1:0] key_r  [ENTRIES];
  logic [IW-1:0]               rank_r [ENTRIES];
  logic [OW-1:0]               occ_r;
  logic [lrukv_pkg::VAL_W-1:0] data_mem_r [ENTRIES];

  // Lookup results
  logic [IW-1:0]               slot_r;
  logic [IW-1:0]               rsel_r;
  logic                        hit_r;
  logic                        wasv_r;
  logic                        free_r;
  logic [lrukv_pkg::VAL_W-1:0] rdata_r;

  // Result register
  logic                        found_r;
  logic [lrukv_pkg::VAL_W-1:0] result_r;

  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] lru_m;
  logic [IW-1:0]      hit_idx;
  logic [IW-1:0]      hit_rank;
  logic [IW-1:0]      lru_idx;
  logic [IW-1:0]      free_idx;
  logic [IW-1:0]      lru_rank;
  logic [CMW-1:0]     cap_eff;
  logic               hit;
  logic               has_room;
  logic               upd_en;
  logic               put_miss;

  // Request register
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r    <= in_op;
      key_q_r <= in_key;
      value_r <= in_value;
    end
  end

  // Effective capacity: zero acts as one, clipped to the entry count
  always_comb begin
    cap_eff = CMW'(capacity);
    if (cap_eff == '0) begin
      cap_eff = CMW'(1);
    end else if (cap_eff > CMW'(ENTRIES)) begin
      cap_eff = CMW'(ENTRIES);
    end
  end

  // Ranks of valid entries are a permutation of 0..occ-1, so the LRU is rank occ-1
  assign lru_rank = IW'(occ_r - OW'(1));
  assign has_room = CMW'(occ_r) < cap_eff;

  // Parallel key compare and LRU match
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid_r[i] && (key_r[i] == key_q_r);
      lru_m[i] = valid_r[i] && (rank_r[i] == lru_rank);
    end
  end
  assign hit = |match;

  // One-hot encoders (matches are unique) and lowest free slot
  always_comb begin
    hit_idx  = '0;
    hit_rank = '0;
    lru_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match[i]) begin
        hit_idx  = hit_idx | IW'(i);
        hit_rank = hit_rank | rank_r[i];
      end
      if (lru_m[i]) begin
        lru_idx = lru_idx | IW'(i);
      end
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = IW'(i);
      end
    end
  end

  // Lookup stage registers
  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      hit_r  <= hit;
      free_r <= has_room;
      if (hit) begin
        slot_r <= hit_idx;
        rsel_r <= hit_rank;
        wasv_r <= 1'b1;
      end else if (has_room) begin
        slot_r <= free_idx;
        rsel_r <= '0;
        wasv_r <= 1'b0;
      end else begin
        slot_r <= lru_idx;
        rsel_r <= lru_rank;
        wasv_r <= 1'b1;
      end
    end
  end

  assign upd_en   = cmd.commit && (hit_r || (op_r == lrukv_pkg::OP_PUT));
  assign put_miss = (op_r == lrukv_pkg::OP_PUT) && !hit_r;

  // Data memory: read at the hit slot during lookup, written on put commit
  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      rdata_r <= data_mem_r[hit_idx];
    end
    if (cmd.commit && (op_r == lrukv_pkg::OP_PUT)) begin
      data_mem_r[slot_r] <= value_r;
    end
  end

  // Key store written on a put miss
  always_ff @(posedge clk) begin
    if (cmd.commit && put_miss) begin
      key_r[slot_r] <= key_q_r;
    end
  end

  // Recency, valid and occupancy update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      occ_r   <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else if (upd_en) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (IW'(i) == slot_r) begin
          rank_r[i]  <= '0;
          valid_r[i] <= 1'b1;
        end else if (valid_r[i] && (!wasv_r || (rank_r[i] < rsel_r))) begin
          rank_r[i] <= rank_r[i] + IW'(1);
        end
      end
      if (put_miss && free_r) begin
        occ_r <= occ_r + OW'(1);
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      found_r  <= hit_r;
      result_r <= (hit_r && (op_r == lrukv_pkg::OP_GET)) ? rdata_r : '0;
    end
  end

  assign out_found      = found_r;
  assign out_read_value = signed'(result_r);

endmodule

### src/lru_key_value_cache_unit.sv
// lru_key_value_cache_unit: top level of the LRU key-value cache.
// Instantiates lrukv_ctrl and lrukv_dpath; uses lrukv_pkg; holds the APB capacity register.

// Fully associative key-value cache with least-recently-used replacement. Each input
// beat is a get (op 0) or a put (op 1) and produces exactly one result beat: found tells
// whether the key was present, read_value carries the stored value on a get hit and zero
// otherwise. A put miss fills the lowest free slot while occupancy is below capacity,
// else it replaces the least recently used entry. An item passes through a lookup state for the
// parallel key compare across all entries (with the data memory read) and an update state for the
// recency, key and data update; a new beat is taken in the update state, so back-to-back
// items overlap as long as the result register drains. Capacity sits at byte address 0
// and should be written only while the cache is idle.
module lru_key_value_cache_unit #(
  parameter int ENTRIES = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_op,
  input  logic [lrukv_pkg::KEY_W-1:0]         in_key,
  input  logic signed [lrukv_pkg::VAL_W-1:0]  in_value,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_found,
  output logic signed [lrukv_pkg::VAL_W-1:0]  out_read_value,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lrukv_pkg::CFG_AW-1:0]        paddr,
  input  logic [lrukv_pkg::CFG_DW-1:0]        pwdata,
  output logic [lrukv_pkg::CFG_DW-1:0]        prdata,
  output logic                                pready
);

  logic [lrukv_pkg::CAP_W-1:0] cap_r;
  lrukv_pkg::cmd_t             cmd;
  logic                        cfg_wr;

  // Capacity register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == lrukv_pkg::REG_CAPACITY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= lrukv_pkg::CAP_RESET;
    end else if (cfg_wr) begin
      cap_r <= pwdata[lrukv_pkg::CAP_W-1:0];
    end
  end

  assign prdata = (paddr[2] == lrukv_pkg::REG_CAPACITY) ?
                  lrukv_pkg::CFG_DW'(cap_r) : '0;

  lrukv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  lrukv_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .capacity       (cap_r),
    .in_op          (in_op),
    .in_key         (in_key),
    .in_value       (in_value),
    .out_found      (out_found),
    .out_read_value (out_read_value)
  );

  // An accepted beat goes to lookup in the next cycle
  a_accept_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> cmd.lookup)
    else $error("accepted beat did not enter lookup");

  // A commit always presents a result beat
  a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid)
    else $error("commit without result beat");

  // Lookup never overlaps an accept or a commit
  a_lookup_alone: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.lookup |-> (!cmd.accept && !cmd.commit && in_stall))
    else $error("lookup overlaps accept or commit");

endmodule

### bench/lrukv_result_checker.sv
// lrukv_result_checker: watches the beats of the LRU key-value cache, predicts
// each result from its own copy of the cache state and compares. Depends on lrukv_pkg.
module lrukv_result_checker #(
  parameter int ENTRIES = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic                           in_op,
  input  logic [lrukv_pkg::KEY_W-1:0]    in_key,
  input  logic [lrukv_pkg::VAL_W-1:0]    in_value,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic                           out_found,
  input  logic [lrukv_pkg::VAL_W-1:0]    out_read_value,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lrukv_pkg::CFG_AW-1:0]   paddr,
  input  logic [lrukv_pkg::CFG_DW-1:0]   pwdata,
  input  logic [lrukv_pkg::CFG_DW-1:0]   prdata,
  input  logic                           pready,
  output int                             n_pending,
  output int                             n_errors
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [lrukv_pkg::CFG_AW-1:0] CAPACITY_ADDR =
    lrukv_pkg::CFG_AW'(lrukv_pkg::REG_CAPACITY) << 2;

  typedef struct packed {
    logic                        found;
    logic [lrukv_pkg::VAL_W-1:0] read_value;
  } lookup_t;

  // expected results, oldest first
  lookup_t expected_lookups[$];

  // shadow of the cache contents
  logic                        slot_valid[ENTRIES];
  logic [lrukv_pkg::KEY_W-1:0] slot_key[ENTRIES];
  logic [lrukv_pkg::VAL_W-1:0] slot_data[ENTRIES];
  int                          slot_rank[ENTRIES];  // 0 = most recent
  int                          fill_count;
  logic [lrukv_pkg::CAP_W-1:0] capacity;

  function automatic void note_mismatch(string what);
    if (n_errors < 10)
      $display("%0t ns: mismatch: %s", $realtime, what);
    n_errors++;
  endfunction

  // Move slot s to the front; entries that were more recent age by one
  function automatic void promote_slot(int s, bit was_valid);
    int r;
    r = slot_rank[s];
    for (int i = 0; i < ENTRIES; i++) begin
      if (i != s && slot_valid[i] && (!was_valid || slot_rank[i] < r))
        slot_rank[i]++;
    end
    slot_rank[s]  = 0;
    slot_valid[s] = 1'b1;
  endfunction

  // Apply one get or put to the shadow cache and return its result
  function automatic lookup_t cache_access(logic op, logic [lrukv_pkg::KEY_W-1:0] key,
                                           logic [lrukv_pkg::VAL_W-1:0] val);
    lookup_t res;
    int      cap;
    int      slot;
    int      oldest;
    bit      hit;
    bit      have_free;
    bit      any;
    cap = (capacity == 0) ? 1 : int'(capacity);
    if (cap > ENTRIES)
      cap = ENTRIES;
    hit  = 1'b0;
    slot = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!hit && slot_valid[i] && slot_key[i] == key) begin
        hit  = 1'b1;
        slot = i;
      end
    end
    res.found      = hit;
    res.read_value = '0;
    if (op == lrukv_pkg::OP_GET) begin
      if (hit) begin
        res.read_value = slot_data[slot];
        promote_slot(slot, 1'b1);
      end
    end else if (hit) begin
      slot_data[slot] = val;
      promote_slot(slot, 1'b1);
    end else begin
      // miss: lowest free slot while below capacity, else the least recent entry
      have_free = 1'b0;
      any       = 1'b0;
      oldest    = 0;
      if (fill_count < cap) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (!have_free && !slot_valid[i]) begin
            slot      = i;
            have_free = 1'b1;
          end
        end
      end
      if (!have_free) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_valid[i] && (!any || slot_rank[i] > oldest)) begin
            oldest = slot_rank[i];
            slot   = i;
            any    = 1'b1;
          end
        end
      end
      slot_key[slot]  = key;
      slot_data[slot] = val;
      promote_slot(slot, !have_free && any);
      if (have_free || !any)
        fill_count++;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    lookup_t want;
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        slot_valid[i] = 1'b0;
        slot_rank[i]  = 0;
        slot_key[i]   = '0;
        slot_data[i]  = '0;
      end
      fill_count = 0;
      capacity   = lrukv_pkg::CAP_RESET;
      expected_lookups.delete();
      n_errors   = 0;
    end else begin
      // register access
      if (psel && penable && pready && paddr == CAPACITY_ADDR) begin
        if (pwrite)
          capacity = pwdata[lrukv_pkg::CAP_W-1:0];
        else if (prdata[lrukv_pkg::CAP_W-1:0] !== capacity)
          note_mismatch($sformatf("capacity readback exp %0d got %0d",
                                  capacity, prdata[lrukv_pkg::CAP_W-1:0]));
      end
      // input beat
      if (in_valid && !in_stall)
        expected_lookups.push_back(cache_access(in_op, in_key, in_value));
      // result beat
      if (out_valid && !out_stall) begin
        if (expected_lookups.size() == 0) begin
          note_mismatch($sformatf("unexpected result found=%0b read_value=%h",
                                  out_found, out_read_value));
        end else begin
          want = expected_lookups.pop_front();
          if (want.found !== out_found || want.read_value !== out_read_value)
            note_mismatch($sformatf("exp found=%0b read_value=%h got found=%0b read_value=%h",
                                    want.found, want.read_value, out_found,
                                    out_read_value));
        end
      end
    end
    n_pending = expected_lookups.size();
  end

endmodule

### bench/tb_lru_key_value_cache_unit.sv
// tb_lru_key_value_cache_unit: stimulus and verdict for lru_key_value_cache_unit.
// Uses lrukv_pkg and lrukv_result_checker, which predicts and compares the results.
module tb_lru_key_value_cache_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES       = 16;
  localparam int QUIET_LIMIT   = 5000;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 145;
  localparam logic [lrukv_pkg::CFG_AW-1:0] CAPACITY_ADDR =
    lrukv_pkg::CFG_AW'(lrukv_pkg::REG_CAPACITY) << 2;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic                          clk      = 1'b0;
  logic                          rst_n    = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          in_op    = lrukv_pkg::OP_GET;
  logic [lrukv_pkg::KEY_W-1:0]   in_key   = '0;
  logic [lrukv_pkg::VAL_W-1:0]   in_value = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic                          out_found;
  logic [lrukv_pkg::VAL_W-1:0]   out_read_value;
  logic                          psel     = 1'b0;
  logic                          penable  = 1'b0;
  logic                          pwrite   = 1'b0;
  logic [lrukv_pkg::CFG_AW-1:0]  paddr    = '0;
  logic [lrukv_pkg::CFG_DW-1:0]  pwdata   = '0;
  logic [lrukv_pkg::CFG_DW-1:0]  prdata;
  logic                          pready;
  int                            n_pending;
  int                            n_errors;

  int                  burst_left   = 0;
  bit                  steady       = 1'b0;
  stall_mode_t         stall_mode   = STALL_NONE;
  int                  stall_left   = 0;
  int                  stall_tick   = 0;
  int                  quiet_cycles = 0;

  lru_key_value_cache_unit #(.ENTRIES(ENTRIES)) u_top (.*);

  lrukv_result_checker #(.ENTRIES(ENTRIES)) u_checker (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  // receiver back-pressure: a randomly chosen mode, changed when its countdown runs out
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(40, 300);
    end else begin
      stall_left--;
    end
    stall_tick++;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 99) < 30);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 99) < 80);
      default:     out_stall <= (stall_tick % 6) < 2;
    endcase
  end

  // watchdog on cycles without any beat or register access
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one input beat; bursts of random length with idle gaps unless steady
  task automatic send_beat(input logic op, input logic [lrukv_pkg::KEY_W-1:0] key,
                           input logic [lrukv_pkg::VAL_W-1:0] val);
    int gap;
    if (burst_left == 0) begin
      if (!steady) begin
        gap = $urandom_range(1, 6);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_op    <= op;
    in_key   <= key;
    in_value <= val;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  // stop sending and wait until every result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (n_pending != 0) @(negedge clk);
    repeat (3) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic cfg_access(input bit wr, input logic [lrukv_pkg::CFG_AW-1:0] addr,
                            input logic [lrukv_pkg::CFG_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // write capacity while idle, then read it back
  task automatic set_capacity(input logic [lrukv_pkg::CAP_W-1:0] cap);
    wait_drained();
    cfg_access(1'b1, CAPACITY_ADDR, lrukv_pkg::CFG_DW'(cap));
    cfg_access(1'b0, CAPACITY_ADDR, '0);
  endtask

  initial begin
    logic [lrukv_pkg::KEY_W-1:0] key_pool[24];
    logic [lrukv_pkg::KEY_W-1:0] key;
    logic [lrukv_pkg::CAP_W-1:0] cap;
    int                          pool_n;
    int                          eff;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty miss, field extremes, update on hit, free-slot fill
    send_beat(lrukv_pkg::OP_GET, 16'h0000, 32'h0000_0000);
    send_beat(lrukv_pkg::OP_PUT, 16'h0000, 32'h7FFF_FFFF);
    send_beat(lrukv_pkg::OP_PUT, 16'hFFFF, 32'h8000_0000);
    send_beat(lrukv_pkg::OP_GET, 16'h0000, 32'hFFFF_FFFF);
    send_beat(lrukv_pkg::OP_GET, 16'hFFFF, 32'h0000_0000);
    send_beat(lrukv_pkg::OP_PUT, 16'h0000, 32'hFFFF_FFFF);
    send_beat(lrukv_pkg::OP_GET, 16'h0000, 32'h0000_0000);
    send_beat(lrukv_pkg::OP_GET, 16'h5A5A, 32'h0000_0000);
    send_beat(lrukv_pkg::OP_PUT, 16'h0001, 32'h0000_0000);

    // capacity zero acts as one, set below occupancy: misses replace the oldest
    set_capacity(5'd0);
    send_beat(lrukv_pkg::OP_PUT, 16'h0002, 32'h1234_5678);
    send_beat(lrukv_pkg::OP_GET, 16'hFFFF, 32'h0000_0000);
    send_beat(lrukv_pkg::OP_GET, 16'h0002, 32'h0000_0000);
    send_beat(lrukv_pkg::OP_PUT, 16'h0003, 32'hA5A5_A5A5);
    send_beat(lrukv_pkg::OP_GET, 16'h0000, 32'h0000_0000);
    send_beat(lrukv_pkg::OP_GET, 16'h0001, 32'h0000_0000);

    // capacity above the entry count is clamped
    set_capacity(5'd31);
    for (int i = 0; i < 4; i++)
      send_beat(lrukv_pkg::OP_PUT, lrukv_pkg::KEY_W'(16'h0100 + i), $urandom());
    send_beat(lrukv_pkg::OP_GET, 16'h0101, 32'h0000_0000);
    send_beat(lrukv_pkg::OP_GET, 16'h0003, 32'h0000_0000);

    // random phases: keys mostly from a pool sized around the capacity
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0:       cap = 5'd1;
        1:       cap = 5'd16;
        2:       cap = 5'd31;
        3:       cap = 5'd0;
        default: cap = lrukv_pkg::CAP_W'($urandom_range(0, 31));
      endcase
      set_capacity(cap);
      eff = (cap == 0) ? 1 : int'(cap);
      if (eff > ENTRIES)
        eff = ENTRIES;
      pool_n = eff + $urandom_range(1, 8);
      for (int k = 0; k < pool_n; k++)
        key_pool[k] = lrukv_pkg::KEY_W'($urandom_range(0, 65535));
      steady = (ph % 3 == 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < 12)
          key = lrukv_pkg::KEY_W'($urandom_range(0, 65535));
        else
          key = key_pool[$urandom_range(0, pool_n - 1)];
        send_beat(1'($urandom_range(0, 1)), key, $urandom());
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (n_errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
